### hdl/multi_channel_pwm_breathing_core_macros.svh
// ----------------------------------------------------------------------------
// assertion macros for the pwm breathing core checker
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_PWM_BREATHING_CORE_MACROS_SVH
`define MULTI_CHANNEL_PWM_BREATHING_CORE_MACROS_SVH

// property checked outside reset
`define MCPB_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("mcpb assertion failed");

// property checked at every edge, reset included
`define MCPB_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("mcpb assertion failed during or after reset");

`endif

### hdl/mcpb_pkg.sv
// ----------------------------------------------------------------------------
// mcpb_pkg
// shared types, codes and helpers of the multi-channel pwm breathing core
// ----------------------------------------------------------------------------
`default_nettype none

package mcpb_pkg;

    // default channel count and port field widths
    localparam int unsigned CHANNELS_DEF = 8;
    localparam int unsigned MASK_W       = 8;
    localparam int unsigned LEVEL_W      = 8;
    localparam int unsigned S_DATA_W     = 24;
    localparam int unsigned M_DATA_W     = 16;

    // item actions
    typedef enum logic [2:0] {
        ACT_PERIOD = 3'd0,
        ACT_STEP   = 3'd1,
        ACT_DUTY   = 3'd2,
        ACT_PEAK   = 3'd3,
        ACT_FON    = 3'd4,
        ACT_FOFF   = 3'd5
    } action_t;

    // per-channel mode, one-hot
    typedef enum logic [3:0] {
        MODE_OFF    = 4'b0001,
        MODE_STEADY = 4'b0010,
        MODE_RISE   = 4'b0100,
        MODE_FALL   = 4'b1000
    } mode_t;

    // one registered input beat
    typedef struct packed {
        logic [7:0] value;
        logic [7:0] channel_mask;
        logic [2:0] action;
    } beat_t;

    // control shared by all channel slices
    typedef struct packed {
        logic       step;
        logic       set_duty;
        logic       set_peak;
        logic [7:0] value;
        logic [7:0] step_count;
    } chan_ctrl_t;

    // floor(d / 20) by reciprocal multiply, exact for 8-bit d
    function automatic logic [3:0] div20(input logic [7:0] d);
        logic [15:0] p;
        p = 16'(d) * 16'd205;
        return p[15:12];
    endfunction

endpackage

`default_nettype wire

### hdl/mcpb_in_stage.sv
// ----------------------------------------------------------------------------
// mcpb_in_stage
// input register of the pwm core, takes a beat whenever it is empty or drained
// ----------------------------------------------------------------------------
`default_nettype none

module mcpb_in_stage (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [23:0]          s_tdata,   // action[2:0], channel_mask[10:3], value[18:11]
    input  wire logic                 take,
    output logic                      valid,
    output mcpb_pkg::beat_t           beat
);

    logic            valid_reg;
    logic            valid_next;
    mcpb_pkg::beat_t beat_reg;
    logic            accept;

    // handshake
    assign s_tready = !valid_reg || take;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    // occupancy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, loaded on accept
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            beat_reg <= s_tdata[18:0];
        end
    end

    assign valid = valid_reg;
    assign beat  = beat_reg;

endmodule

`default_nettype wire

### hdl/mcpb_channel.sv
// ----------------------------------------------------------------------------
// mcpb_channel
// one pwm channel: duty, peak and mode, the count compare and the breathe step
// ----------------------------------------------------------------------------
`default_nettype none

module mcpb_channel (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire mcpb_pkg::chan_ctrl_t ctrl,
    input  wire logic                 sel,
    input  wire logic                 pending,
    output logic                      dark
);

    logic [7:0]      duty_reg;
    logic [7:0]      duty_next;
    logic [7:0]      peak_reg;
    logic [7:0]      peak_next;
    mcpb_pkg::mode_t mode_reg;
    mcpb_pkg::mode_t mode_next;
    logic [3:0]      delta;
    logic [8:0]      sum;

    // channel reaches its duty at this count
    assign dark = pending && (duty_reg <= ctrl.step_count);

    // breathe step size, at least one
    always_comb
    begin
        delta = mcpb_pkg::div20(duty_reg);
        if (delta == 4'd0)
        begin
            delta = 4'd1;
        end
    end

    assign sum = {1'b0, duty_reg} + {5'd0, delta};

    // next duty, peak and mode
    always_comb
    begin
        duty_next = duty_reg;
        peak_next = peak_reg;
        mode_next = mode_reg;
        if (ctrl.step && dark)
        begin
            case (mode_reg)
                mcpb_pkg::MODE_RISE:
                begin
                    if (duty_reg >= peak_reg)
                    begin
                        mode_next = mcpb_pkg::MODE_FALL;
                    end
                    else
                    begin
                        duty_next = sum[8] ? 8'hFF : sum[7:0];
                    end
                end
                mcpb_pkg::MODE_FALL:
                begin
                    if (duty_reg <= 8'd1)
                    begin
                        mode_next = mcpb_pkg::MODE_RISE;
                    end
                    else
                    begin
                        duty_next = duty_reg - {4'd0, delta};
                    end
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
        else if (ctrl.set_duty && sel)
        begin
            mode_next = mcpb_pkg::MODE_STEADY;
            duty_next = ctrl.value;
        end
        else if (ctrl.set_peak && sel)
        begin
            mode_next = mcpb_pkg::MODE_RISE;
            peak_next = ctrl.value;
        end
    end

    // channel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_reg <= 8'd0;
            peak_reg <= 8'd0;
            mode_reg <= mcpb_pkg::MODE_OFF;
        end
        else
        begin
            duty_reg <= duty_next;
            peak_reg <= peak_next;
            mode_reg <= mode_next;
        end
    end

endmodule

`default_nettype wire

### hdl/multi_channel_pwm_breathing_core.sv
// path: an accepted beat waits in the input register, then moves to the result register
// and leaves from there when the output side is not stalled
// throughput: one beat per cycle while the output side is not stalled; all channels update
// in parallel in a single pass between the input register and the result register
// reset: asynchronous, active low; clears all channel and mask state
// ----------------------------------------------------------------------------
// multi_channel_pwm_breathing_core
// multi-channel led pwm with steady and breathing channels, stream ports
// ----------------------------------------------------------------------------
`default_nettype none

module multi_channel_pwm_breathing_core #(
    parameter int unsigned CHANNELS = mcpb_pkg::CHANNELS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // action[2:0], channel_mask[10:3], value[18:11]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // led_levels[7:0], sweep_active[8]
);

    logic                in_valid;
    mcpb_pkg::beat_t     beat;
    logic                take;
    logic                go;
    mcpb_pkg::action_t   act;
    mcpb_pkg::chan_ctrl_t ctrl;

    logic [CHANNELS-1:0] mask;
    logic [CHANNELS-1:0] dark;
    logic [CHANNELS-1:0] enabled_reg, enabled_next;
    logic [CHANNELS-1:0] forced_reg, forced_next;
    logic [CHANNELS-1:0] pending_reg, pending_next;
    logic [CHANNELS-1:0] outbits_reg, outbits_next;
    logic [7:0]          count_reg, count_next;

    logic                out_valid_reg, out_valid_next;
    logic [7:0]          led_reg;
    logic                sweep_reg;
    logic [7:0]          led_next;

    // input register
    mcpb_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .take     (take),
        .valid    (in_valid),
        .beat     (beat)
    );

    // result register frees up or drains this cycle
    assign take = !out_valid_reg || m_tready;
    assign go   = in_valid && take;
    assign act  = mcpb_pkg::action_t'(beat.action);

    // mask bits beyond the port or the channel count drop out
    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_mask
        if (c < mcpb_pkg::MASK_W)
        begin : g_bit
            assign mask[c] = beat.channel_mask[c];
        end
        else
        begin : g_zero
            assign mask[c] = 1'b0;
        end
    end

    // shared channel control
    assign ctrl.step       = go && (act == mcpb_pkg::ACT_STEP);
    assign ctrl.set_duty   = go && (act == mcpb_pkg::ACT_DUTY);
    assign ctrl.set_peak   = go && (act == mcpb_pkg::ACT_PEAK);
    assign ctrl.value      = beat.value;
    assign ctrl.step_count = count_reg;

    // channel slices
    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_chan
        mcpb_channel u_chan (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .sel     (mask[c]),
            .pending (pending_reg[c]),
            .dark    (dark[c])
        );
    end

    // shared masks and count
    always_comb
    begin
        enabled_next = enabled_reg;
        forced_next  = forced_reg;
        pending_next = pending_reg;
        outbits_next = outbits_reg;
        count_next   = count_reg;
        if (go)
        begin
            case (act)
                mcpb_pkg::ACT_PERIOD:
                begin
                    outbits_next = enabled_reg | forced_reg;
                    pending_next = enabled_reg;
                    count_next   = 8'd0;
                end
                mcpb_pkg::ACT_STEP:
                begin
                    outbits_next = outbits_reg & ~dark;
                    pending_next = pending_reg & ~dark;
                    if (count_reg != 8'hFF)
                    begin
                        count_next = count_reg + 8'd1;
                    end
                end
                mcpb_pkg::ACT_DUTY,
                mcpb_pkg::ACT_PEAK:
                begin
                    enabled_next = enabled_reg | mask;
                    forced_next  = forced_reg & ~mask;
                end
                mcpb_pkg::ACT_FON:
                begin
                    enabled_next = enabled_reg & ~mask;
                    pending_next = pending_reg & ~mask;
                    forced_next  = forced_reg | mask;
                end
                mcpb_pkg::ACT_FOFF:
                begin
                    enabled_next = enabled_reg & ~mask;
                    pending_next = pending_reg & ~mask;
                    forced_next  = forced_reg & ~mask;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= '0;
            forced_reg  <= '0;
            pending_reg <= '0;
            outbits_reg <= '0;
            count_reg   <= 8'd0;
        end
        else
        begin
            enabled_reg <= enabled_next;
            forced_reg  <= forced_next;
            pending_reg <= pending_next;
            outbits_reg <= outbits_next;
            count_reg   <= count_next;
        end
    end

    // led levels on the port width
    for (genvar j = 0; j < mcpb_pkg::LEVEL_W; j++)
    begin : g_led
        if (j < CHANNELS)
        begin : g_bit
            assign led_next[j] = outbits_next[j];
        end
        else
        begin : g_zero
            assign led_next[j] = 1'b0;
        end
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (go)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            led_reg   <= led_next;
            sweep_reg <= |pending_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, sweep_reg, led_reg};

endmodule

`default_nettype wire

### hdl/mcpb_checker.sv
// ----------------------------------------------------------------------------
// mcpb_checker
// port-level checks of the pwm breathing core, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
`include "multi_channel_pwm_breathing_core_macros.svh"

module mcpb_checker #(
    parameter int unsigned CHANNELS = mcpb_pkg::CHANNELS_DEF
) (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [23:0] s_tdata,   // action[2:0], channel_mask[10:3], value[18:11]
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata    // led_levels[7:0], sweep_active[8]
);

    localparam int unsigned LIVE_W = (CHANNELS < 8) ? CHANNELS : 8;
    localparam logic [7:0]  LiveMask = 8'((9'd1 << LIVE_W) - 9'd1);

    // the input side is ready whenever no result is held
    `MCPB_ASSERT(a_ready_when_out_empty, !m_tvalid |-> s_tready)

    // a stalled result holds
    `MCPB_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

    // padding and absent channels stay dark
    `MCPB_ASSERT(a_pad_zero, m_tvalid |-> m_tdata[15:9] == 7'd0)
    `MCPB_ASSERT(a_absent_dark, m_tvalid |-> (m_tdata[7:0] & ~LiveMask) == 8'd0)

    // no result at the edge after one seen in reset
    `MCPB_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !m_tvalid)

endmodule

bind multi_channel_pwm_breathing_core mcpb_checker #(.CHANNELS(CHANNELS)) u_mcpb_checker (.*);

`default_nettype wire
